/* rtl/geq_pkg.sv */
package geq_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_TRIGGER_LEVEL  = 3'd0,
    REG_CLICK_TOGGLE   = 3'd1,
    REG_FIRST_DELAY    = 3'd2,
    REG_NEXT_DELAY     = 3'd3,
    REG_LEFT_DEADZONE  = 3'd4,
    REG_RIGHT_DEADZONE = 3'd5
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [7:0]  RST_TRIGGER_LEVEL  = 8'd30;
  localparam logic [15:0] RST_FIRST_DELAY    = 16'd220;
  localparam logic [15:0] RST_NEXT_DELAY     = 16'd160;
  localparam logic [14:0] RST_LEFT_DEADZONE  = 15'd7849;
  localparam logic [14:0] RST_RIGHT_DEADZONE = 15'd8689;

  // Key codes and button bit positions
  localparam int NUM_KEYS    = 25;
  localparam int RPT_KEYS    = 12;
  localparam int KEY_DPAD    = 8;
  localparam int KEY_BUTTON  = 12;
  localparam int KEY_CLICK   = 19;
  localparam int KEY_SHOULD  = 21;
  localparam int KEY_TRIGGER = 23;
  localparam int BIT_CLICK   = 7;
  localparam int BIT_SHOULD  = 9;
  localparam int BIT_DPAD    = 11;

  // Stick direction math
  localparam logic [15:0] SQRT_HALF_Q16 = 16'd46341;
  localparam logic [14:0] AXIS_FULL     = 15'd32767;
  localparam logic [1:0]  DIR_UP        = 2'd0;
  localparam logic [1:0]  DIR_DOWN      = 2'd1;
  localparam logic [1:0]  DIR_LEFT      = 2'd2;
  localparam logic [1:0]  DIR_RIGHT     = 2'd3;

  typedef enum logic [3:0] {
    DS_IDLE,
    DS_SQX,
    DS_SQY,
    DS_SUM,
    DS_ROOT,
    DS_CHECK,
    DS_MD,
    DS_SMD,
    DS_XN,
    DS_YN,
    DS_DECIDE
  } dir_state_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_DIR,
    TS_KEYS,
    TS_FINISH
  } top_state_t;

  // Status of the direction unit toward the sequencer
  typedef struct packed {
    logic       busy;
    logic       done;
    logic       hit;
    logic [1:0] code;
  } dir_res_t;

endpackage

/* rtl/geq_dir_unit.sv */
module geq_dir_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic [14:0]        dz,
  output geq_pkg::dir_res_t  res
);
  import geq_pkg::*;

  dir_state_t  state;
  dir_state_t  state_next;
  logic [15:0] ax;
  logic [15:0] ay;
  logic        xneg;
  logic        yneg;
  logic [14:0] dzr;
  logic [47:0] prod;
  logic [31:0] acc;
  logic [31:0] rem;
  logic [31:0] root;
  logic [31:0] bitv;
  logic [3:0]  cnt;
  logic [15:0] mval;
  logic [14:0] nreg;
  logic [14:0] dreg;
  logic [46:0] rhs;
  logic [30:0] lx;
  logic        done;
  logic        hit;
  logic [1:0]  code;

  logic [15:0] mul_a;
  logic [31:0] mul_b;
  logic [47:0] mul_p;
  logic [31:0] trial;
  logic [15:0] mcur;
  logic [14:0] clip;
  logic [14:0] nval;
  logic        gx;
  logic        gy;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      DS_IDLE:   if (start) state_next = DS_SQX;
      DS_SQX:    state_next = DS_SQY;
      DS_SQY:    state_next = DS_SUM;
      DS_SUM:    state_next = DS_ROOT;
      DS_ROOT:   if (cnt == 4'd15) state_next = DS_CHECK;
      DS_CHECK: begin
        if ({1'b0, dz} >= mcur || nval == 15'd0) state_next = DS_IDLE;
        else state_next = DS_MD;
      end
      DS_MD:     state_next = DS_SMD;
      DS_SMD:    state_next = DS_XN;
      DS_XN:     state_next = DS_YN;
      DS_YN:     state_next = DS_DECIDE;
      DS_DECIDE: state_next = DS_IDLE;
      default:   state_next = DS_IDLE;
    endcase
  end

  // Operand select of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      DS_SQX: begin
        mul_a = ax;
        mul_b = {16'd0, ax};
      end
      DS_SQY: begin
        mul_a = ay;
        mul_b = {16'd0, ay};
      end
      DS_MD: begin
        mul_a = mval;
        mul_b = {17'd0, dreg};
      end
      DS_SMD: begin
        mul_a = SQRT_HALF_Q16;
        mul_b = prod[31:0];
      end
      DS_XN: begin
        mul_a = ax;
        mul_b = {17'd0, nreg};
      end
      DS_YN: begin
        mul_a = ay;
        mul_b = {17'd0, nreg};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign trial = root + bitv;
  assign mcur  = root[15:0];
  assign clip  = (mcur > {1'b0, AXIS_FULL}) ? AXIS_FULL : mcur[14:0];
  assign nval  = clip - dz;
  assign gx    = {lx, 16'd0} > rhs;
  assign gy    = {prod[30:0], 16'd0} > rhs;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DS_DECIDE) ||
               (state == DS_CHECK && state_next == DS_IDLE);
    end
  end

  // Datapath: squares, bitwise root, scaled compares
  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (state)
      DS_IDLE: begin
        if (start) begin
          ax   <= x[15] ? 16'(-x) : 16'(x);
          ay   <= y[15] ? 16'(-y) : 16'(y);
          xneg <= x[15];
          yneg <= y[15];
          dzr  <= dz;
        end
      end
      DS_SQY: acc <= prod[31:0];
      DS_SUM: begin
        rem  <= acc + prod[31:0];
        root <= '0;
        bitv <= 32'h4000_0000;
        cnt  <= '0;
      end
      DS_ROOT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 4'd1;
      end
      DS_CHECK: begin
        mval <= mcur;
        nreg <= nval;
        dreg <= AXIS_FULL - dzr;
        hit  <= 1'b0;
      end
      DS_XN: rhs <= prod[46:0];
      DS_YN: lx <= prod[30:0];
      DS_DECIDE: begin
        hit <= 1'b1;
        if (!xneg && gx) code <= DIR_RIGHT;
        else if (xneg && gx) code <= DIR_LEFT;
        else if (yneg && gy) code <= DIR_UP;
        else if (!yneg && gy) code <= DIR_DOWN;
        else hit <= 1'b0;
      end
      default: ;
    endcase
  end

  assign res.busy = (state != DS_IDLE);
  assign res.done = done;
  assign res.hit  = hit;
  assign res.code = code;

endmodule

/* rtl/gamepad_event_qualifier.sv */
// Game mode: the request goes straight to the finish state, which queues its events;
// the first is then loaded into the output register. Menu mode: four stick evaluations
// (start, squares, 16-step root, scaled compares, hand-off) on one shared multiplier,
// then the 12 repeat keys in turn and a finish state that queues the events.
// A new request is taken once the last event of the previous one is loaded.
// Reset (rst, synchronous): registers to defaults, history and repeat state clear.
module gamepad_event_qualifier #(
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               pad_present,
  input  logic               menu_mode,
  input  logic signed [15:0] left_x,
  input  logic signed [15:0] left_y,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_y,
  input  logic signed [15:0] trigger_left,
  input  logic signed [15:0] trigger_right,
  input  logic [14:0]        button_bits,
  input  logic signed [31:0] now_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         key_code,
  output logic               key_down,
  output logic               last_event
);
  import geq_pkg::*;

  top_state_t state;
  top_state_t state_next;

  logic [7:0]  trigger_level;
  logic        click_toggle_enable;
  logic [15:0] first_repeat_delay;
  logic [15:0] next_repeat_delay;
  logic [14:0] left_deadzone;
  logic [14:0] right_deadzone;

  logic signed [15:0] sax [6];
  logic [14:0]        snb;
  logic               smenu;
  logic signed [TIME_BITS-1:0] snow;
  logic signed [15:0] prev_axes [6];
  logic [14:0]        prev_buttons;

  logic signed [TIME_BITS-1:0] rpt_time [RPT_KEYS];
  logic [RPT_KEYS-1:0] rpt_started;
  logic [1:0]          click_toggled;

  logic [1:0]          slot;
  logic                launch;
  logic [3:0]          kidx;
  logic [3:0]          dhit;
  logic [1:0]          dcode [4];

  logic [NUM_KEYS-1:0] ev_valid;
  logic [NUM_KEYS-1:0] ev_down;
  logic [NUM_KEYS-1:0] pending;

  logic        in_fire;
  logic [63:0] now_wide;
  dir_res_t    dres;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic [14:0] ddz;

  logic [1:0]  grp;
  logic [1:0]  kj;
  logic        held;
  logic        was;
  logic signed [TIME_BITS-1:0] last_t;
  logic [TIME_BITS-1:0] diff;
  logic [15:0] delay;
  logic        send;
  logic [3:0]  dpad_new;
  logic [3:0]  dpad_old;

  logic signed [15:0] th;
  logic [NUM_KEYS-1:0] fin_valid;
  logic [NUM_KEYS-1:0] fin_down;
  logic [1:0]          tog_next;

  logic [4:0]          sel;
  logic [NUM_KEYS-1:0] sel_hot;
  logic                load;

  assign in_ready = (state == TS_IDLE) && (pending == '0);
  assign in_fire  = in_valid && in_ready;
  assign now_wide = {{32{now_time[31]}}, now_time};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      TS_IDLE:   if (in_fire) state_next = menu_mode ? TS_DIR : TS_FINISH;
      TS_DIR:    if (dres.done && slot == 2'd3) state_next = TS_KEYS;
      TS_KEYS:   if (kidx == 4'(RPT_KEYS - 1)) state_next = TS_FINISH;
      TS_FINISH: state_next = TS_IDLE;
      default:   state_next = TS_IDLE;
    endcase
  end

  // Stick operands: new left, old left, new right, old right
  always_comb begin
    case (slot)
      2'd0: begin
        dx = sax[0]; dy = sax[1]; ddz = left_deadzone;
      end
      2'd1: begin
        dx = prev_axes[0]; dy = prev_axes[1]; ddz = left_deadzone;
      end
      2'd2: begin
        dx = sax[2]; dy = sax[3]; ddz = right_deadzone;
      end
      default: begin
        dx = prev_axes[2]; dy = prev_axes[3]; ddz = right_deadzone;
      end
    endcase
  end

  geq_dir_unit u_dir (
    .clk   (clk),
    .rst   (rst),
    .start (launch),
    .x     (dx),
    .y     (dy),
    .dz    (ddz),
    .res   (dres)
  );

  // Repeat decision for the key under the counter
  assign grp      = kidx[3:2];
  assign kj       = kidx[1:0];
  assign dpad_new = snb[BIT_DPAD+3:BIT_DPAD];
  assign dpad_old = prev_buttons[BIT_DPAD+3:BIT_DPAD];

  always_comb begin
    case (grp)
      2'd0: begin
        held = dhit[0] && dcode[0] == kj;
        was  = dhit[1] && dcode[1] == kj;
      end
      2'd1: begin
        held = dhit[2] && dcode[2] == kj;
        was  = dhit[3] && dcode[3] == kj;
      end
      2'd2: begin
        held = dpad_new[kj];
        was  = dpad_old[kj];
      end
      default: begin
        held = 1'b0;
        was  = 1'b0;
      end
    endcase
  end

  assign last_t = rpt_time[kidx];
  assign diff   = snow - last_t;
  assign delay  = rpt_started[kidx] ? next_repeat_delay : first_repeat_delay;
  assign send   = held && ((snow < last_t) || (diff > TIME_BITS'(delay)));

  // Edge events of d-pad, buttons, clicks, shoulders and triggers
  assign th = signed'({8'd0, trigger_level});

  always_comb begin
    fin_valid = '0;
    fin_down  = '0;
    tog_next  = click_toggled;
    for (int j = 0; j < 4; j++) begin
      fin_valid[KEY_DPAD+j] = snb[BIT_DPAD+j] ^ prev_buttons[BIT_DPAD+j];
      fin_down[KEY_DPAD+j]  = snb[BIT_DPAD+j];
    end
    for (int j = 0; j < 7; j++) begin
      fin_valid[KEY_BUTTON+j] = snb[j] ^ prev_buttons[j];
      fin_down[KEY_BUTTON+j]  = snb[j];
    end
    for (int j = 0; j < 2; j++) begin
      if (!click_toggle_enable || smenu) begin
        tog_next[j]            = 1'b0;
        fin_valid[KEY_CLICK+j] = snb[BIT_CLICK+j] ^ prev_buttons[BIT_CLICK+j];
        fin_down[KEY_CLICK+j]  = snb[BIT_CLICK+j];
      end else if (snb[BIT_CLICK+j] && !prev_buttons[BIT_CLICK+j]) begin
        tog_next[j]            = !click_toggled[j];
        fin_valid[KEY_CLICK+j] = 1'b1;
        fin_down[KEY_CLICK+j]  = !click_toggled[j];
      end
      fin_valid[KEY_SHOULD+j] = snb[BIT_SHOULD+j] ^ prev_buttons[BIT_SHOULD+j];
      fin_down[KEY_SHOULD+j]  = snb[BIT_SHOULD+j];
      fin_valid[KEY_TRIGGER+j] = (sax[4+j] >= th) != (prev_axes[4+j] >= th);
      fin_down[KEY_TRIGGER+j]  = (sax[4+j] >= th);
    end
  end

  // Pick the lowest pending event
  always_comb begin
    sel     = '0;
    sel_hot = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = 5'(i);
      end
    end
    sel_hot[sel] = 1'b1;
  end

  assign load = (pending != '0) && (!out_valid || out_ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level       <= RST_TRIGGER_LEVEL;
      click_toggle_enable <= 1'b0;
      first_repeat_delay  <= RST_FIRST_DELAY;
      next_repeat_delay   <= RST_NEXT_DELAY;
      left_deadzone       <= RST_LEFT_DEADZONE;
      right_deadzone      <= RST_RIGHT_DEADZONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_LEVEL:  trigger_level       <= cfg_data[7:0];
        REG_CLICK_TOGGLE:   click_toggle_enable <= cfg_data[0];
        REG_FIRST_DELAY:    first_repeat_delay  <= cfg_data;
        REG_NEXT_DELAY:     next_repeat_delay   <= cfg_data;
        REG_LEFT_DEADZONE:  left_deadzone       <= cfg_data[14:0];
        REG_RIGHT_DEADZONE: right_deadzone      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer and history
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= TS_IDLE;
      launch        <= 1'b0;
      slot          <= '0;
      kidx          <= '0;
      prev_buttons  <= '0;
      rpt_started   <= '0;
      click_toggled <= '0;
      pending       <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < 6; i++) prev_axes[i] <= '0;
      for (int i = 0; i < RPT_KEYS; i++) rpt_time[i] <= '0;
    end else begin
      state  <= state_next;

      // Start the direction unit on a new menu-mode request or after each stick result but the last
      launch <= in_fire ? menu_mode : (state == TS_DIR && dres.done && slot != 2'd3);

      // Capture the request
      if (in_fire) begin
        sax[0] <= pad_present ? left_x : 16'sd0;
        sax[1] <= pad_present ? left_y : 16'sd0;
        sax[2] <= pad_present ? right_x : 16'sd0;
        sax[3] <= pad_present ? right_y : 16'sd0;
        sax[4] <= pad_present ? trigger_left : 16'sd0;
        sax[5] <= pad_present ? trigger_right : 16'sd0;
        snb    <= pad_present ? button_bits : 15'd0;
        smenu  <= menu_mode;
        snow   <= now_wide[TIME_BITS-1:0];
        slot   <= '0;
        kidx   <= '0;
        ev_valid <= '0;
        ev_down  <= '0;
      end

      // Collect stick directions
      if (state == TS_DIR && dres.done) begin
        dhit[slot]  <= dres.hit;
        dcode[slot] <= dres.code;
        slot        <= slot + 2'd1;
      end

      // Advance through repeat keys
      if (state == TS_KEYS) begin
        kidx <= kidx + 4'd1;
        if (send) begin
          rpt_time[kidx]           <= snow;
          rpt_started[kidx]        <= 1'b1;
          ev_valid[{1'b0, kidx}]   <= 1'b1;
          ev_down[{1'b0, kidx}]    <= 1'b1;
        end else if (!held && was) begin
          rpt_time[kidx]           <= '0;
          rpt_started[kidx]        <= 1'b0;
          ev_valid[{1'b0, kidx}]   <= 1'b1;
          ev_down[{1'b0, kidx}]    <= 1'b0;
        end
      end

      // Close the sample and queue its events
      if (state == TS_FINISH) begin
        if (smenu) begin
          pending <= {fin_valid[NUM_KEYS-1:KEY_BUTTON], ev_valid[KEY_BUTTON-1:0]};
          ev_down <= {fin_down[NUM_KEYS-1:KEY_BUTTON], ev_down[KEY_BUTTON-1:0]};
        end else begin
          pending <= {fin_valid[NUM_KEYS-1:KEY_DPAD], ev_valid[KEY_DPAD-1:0]};
          ev_down <= {fin_down[NUM_KEYS-1:KEY_DPAD], ev_down[KEY_DPAD-1:0]};
        end
        click_toggled <= tog_next;
        prev_buttons  <= snb;
        for (int i = 0; i < 6; i++) prev_axes[i] <= sax[i];
      end else if (load) begin
        pending <= pending & ~sel_hot;
      end

      // Output register
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      key_code   <= sel;
      key_down   <= ev_down[sel];
      last_event <= ((pending & ~sel_hot) == '0);
    end
  end

  a_dir_busy : assert property (@(posedge clk) disable iff (rst)
    dres.busy |-> state == TS_DIR)
    else $error("direction unit running outside stick phase");

  a_pend_idle : assert property (@(posedge clk) disable iff (rst)
    (pending != '0) |-> state == TS_IDLE)
    else $error("events queued while a sample is in work");

  a_keys_range : assert property (@(posedge clk) disable iff (rst)
    state == TS_KEYS |-> kidx < 4'(RPT_KEYS))
    else $error("repeat key counter out of range");

endmodule

/* test/tb_top.sv */
module tb_top;
  import geq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NO_DIR = -1;
  localparam int MAX_EVENTS = 21;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    bit          present;
    bit          menu;
    shortint     lx, ly, rx, ry, tl, tr;
    bit [14:0]   btn;
    int          now;
  } pad_sample_t;

  typedef struct packed {
    logic [4:0] code;
    logic       down;
    logic       last;
  } key_event_t;

  // Expected key events and a bit-true copy of the qualifier state
  class key_event_board;
    int unsigned  trig_level, toggle_en, first_delay, next_delay, dz_left, dz_right;
    shortint      old_axes[6];
    bit [14:0]    old_btn;
    bit [31:0]    rpt_last[RPT_KEYS];
    bit           rpt_started[RPT_KEYS];
    bit           toggled[2];
    key_event_t   pending_q[$];
    key_event_t   batch[$];
    int           errors, seen;

    function new();
      trig_level = RST_TRIGGER_LEVEL;
      toggle_en = 0;
      first_delay = RST_FIRST_DELAY;
      next_delay = RST_NEXT_DELAY;
      dz_left = RST_LEFT_DEADZONE;
      dz_right = RST_RIGHT_DEADZONE;
      old_btn = '0;
      foreach (old_axes[i]) old_axes[i] = 0;
      foreach (rpt_last[i]) begin
        rpt_last[i] = 32'h8000_0000;
        rpt_started[i] = 0;
      end
      toggled[0] = 0;
      toggled[1] = 0;
      errors = 0;
      seen = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, int unsigned v);
      case (idx)
        REG_TRIGGER_LEVEL:  trig_level = v & 8'hFF;
        REG_CLICK_TOGGLE:   toggle_en = v & 1;
        REG_FIRST_DELAY:    first_delay = v & 16'hFFFF;
        REG_NEXT_DELAY:     next_delay = v & 16'hFFFF;
        REG_LEFT_DEADZONE:  dz_left = v & 15'h7FFF;
        REG_RIGHT_DEADZONE: dz_right = v & 15'h7FFF;
        default: ;
      endcase
    endfunction

    function int unsigned root32(int unsigned v);
      int unsigned res, b;
      res = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Radial deadzone, then sort into a direction at sqrt(0.5)
    function int stick_dir(shortint x, shortint y, int unsigned dz);
      longint sq, m, clip, n, d, t, r, xl, yl;
      xl = x;
      yl = y;
      sq = xl * xl + yl * yl;
      m = root32(sq[31:0]);
      if (m <= dz) return NO_DIR;
      clip = (m > AXIS_FULL) ? AXIS_FULL : m;
      n = clip - dz;
      if (n <= 0) return NO_DIR;
      d = AXIS_FULL - dz;
      t = n * 65536;
      r = SQRT_HALF_Q16 * m * d;
      if (xl * t > r) return DIR_RIGHT;
      if (-xl * t > r) return DIR_LEFT;
      if (-yl * t > r) return DIR_UP;
      if (yl * t > r) return DIR_DOWN;
      return NO_DIR;
    endfunction

    function void add(int code, bit down);
      key_event_t e;
      if (batch.size() >= MAX_EVENTS) return;
      e.code = 5'(code);
      e.down = down;
      e.last = 0;
      batch.push_back(e);
    endfunction

    function void repeat_key(int k, bit [31:0] now);
      bit [31:0] delay;
      bit send;
      delay = rpt_started[k] ? next_delay : first_delay;
      send = (now < rpt_last[k]) ? 1 : ((now - rpt_last[k]) > delay);
      if (send) begin
        rpt_last[k] = now;
        rpt_started[k] = 1;
        add(k, 1);
      end
    endfunction

    function void release_key(int k);
      rpt_last[k] = 32'h8000_0000;
      rpt_started[k] = 0;
      add(k, 0);
    endfunction

    function void edge_keys(bit [14:0] nb, bit [14:0] ob, int first_bit, int count, int code);
      for (int k = 0; k < count; k++) begin
        if (nb[first_bit+k] && !ob[first_bit+k]) add(code + k, 1);
        if (!nb[first_bit+k] && ob[first_bit+k]) add(code + k, 0);
      end
    endfunction

    // Work out the events of one accepted request
    function void note_sample(pad_sample_t s);
      shortint ax[6];
      bit [14:0] nb, ob;
      bit [31:0] now;
      int nd, od, th, nv, ov;
      ob = old_btn;
      now = s.now ^ 32'h8000_0000;
      ax[0] = s.present ? s.lx : 0;
      ax[1] = s.present ? s.ly : 0;
      ax[2] = s.present ? s.rx : 0;
      ax[3] = s.present ? s.ry : 0;
      ax[4] = s.present ? s.tl : 0;
      ax[5] = s.present ? s.tr : 0;
      nb = s.present ? s.btn : '0;
      batch.delete();
      if (s.menu) begin
        for (int st = 0; st < 2; st++) begin
          nd = stick_dir(ax[2*st], ax[2*st+1], st ? dz_right : dz_left);
          od = stick_dir(old_axes[2*st], old_axes[2*st+1], st ? dz_right : dz_left);
          for (int k = 0; k < 4; k++) begin
            if (nd == k) repeat_key(4*st + k, now);
            if (nd != k && od == k) release_key(4*st + k);
          end
        end
        for (int k = 0; k < 4; k++) begin
          if (nb[BIT_DPAD+k]) repeat_key(KEY_DPAD + k, now);
          if (!nb[BIT_DPAD+k] && ob[BIT_DPAD+k]) release_key(KEY_DPAD + k);
        end
      end else begin
        edge_keys(nb, ob, BIT_DPAD, 4, KEY_DPAD);
      end
      edge_keys(nb, ob, 0, 7, KEY_BUTTON);
      if (!toggle_en || s.menu) begin
        toggled[0] = 0;
        toggled[1] = 0;
        edge_keys(nb, ob, BIT_CLICK, 2, KEY_CLICK);
      end else begin
        for (int k = 0; k < 2; k++)
          if (nb[BIT_CLICK+k] && !ob[BIT_CLICK+k]) begin
            toggled[k] = !toggled[k];
            add(KEY_CLICK + k, toggled[k]);
          end
      end
      edge_keys(nb, ob, BIT_SHOULD, 2, KEY_SHOULD);
      th = trig_level;
      for (int k = 0; k < 2; k++) begin
        nv = ax[4+k];
        ov = old_axes[4+k];
        if (nv >= th && ov < th) add(KEY_TRIGGER + k, 1);
        if (nv < th && ov >= th) add(KEY_TRIGGER + k, 0);
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1;
      foreach (batch[i]) pending_q.push_back(batch[i]);
      old_axes = ax;
      old_btn = nb;
    endfunction

    function void check_event(logic [4:0] code, logic down, logic last);
      key_event_t e;
      seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected event: code %0d down %b last %b", code, down, last);
        return;
      end
      e = pending_q.pop_front();
      if (code !== e.code || down !== e.down || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected code %0d down %b last %b, got code %0d down %b last %b",
                   e.code, e.down, e.last, code, down, last);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic pad_present, menu_mode;
  logic signed [15:0] left_x, left_y, right_x, right_y, trigger_left, trigger_right;
  logic [14:0] button_bits;
  logic signed [31:0] now_time;
  logic [4:0] key_code;
  logic key_down, last_event;

  key_event_board board;
  bit calm;
  int hold_left;
  int items, menu_items;
  int clock_ms;
  pad_sample_t prev_s;

  gamepad_event_qualifier dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[gamepad_event_qualifier] ERROR");
    $finish;
  end

  // Check every accepted event
  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      board.check_event(key_code, key_down, last_event);

  // Stall the event side at random, or hold off for a long stretch
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 0;
        hold_left--;
      end else if (!calm && $urandom_range(99) < 7) begin
        out_ready = 0;
      end else begin
        out_ready = 1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, int unsigned v);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = 16'(v);
    board.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Wait for all events, then let an eventless sample finish
  task automatic drain();
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(pad_sample_t s);
    if (!calm && $urandom_range(99) < 7) begin
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(8)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1;
    pad_present = s.present;
    menu_mode = s.menu;
    left_x = s.lx;
    left_y = s.ly;
    right_x = s.rx;
    right_y = s.ry;
    trigger_left = s.tl;
    trigger_right = s.tr;
    button_bits = s.btn;
    now_time = s.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(s);
    items++;
    if (s.menu) menu_items++;
    prev_s = s;
    // Drop the request once it is taken
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic shortint pick_axis();
    case ($urandom_range(5))
      0: return 0;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: return shortint'(int'($urandom_range(6000)) - 3000);
      default: return shortint'($urandom);
    endcase
  endfunction

  // Mostly held directions and buttons with a slowly advancing clock
  function automatic pad_sample_t rand_sample();
    pad_sample_t s;
    s = prev_s;
    s.present = $urandom_range(99) < 92;
    if ($urandom_range(99) < 80) s.menu = prev_s.menu;
    else s.menu = 1'($urandom);
    if ($urandom_range(99) < 4) clock_ms = int'($urandom);
    else clock_ms = clock_ms + int'($urandom_range(400));
    s.now = clock_ms;
    if ($urandom_range(99) < 45) begin
      s.lx = pick_axis();
      s.ly = pick_axis();
    end
    if ($urandom_range(99) < 45) begin
      s.rx = pick_axis();
      s.ry = pick_axis();
    end
    if ($urandom_range(99) < 40)
      s.tl = ($urandom_range(1)) ? shortint'($urandom) : shortint'($urandom_range(300));
    if ($urandom_range(99) < 40)
      s.tr = ($urandom_range(1)) ? shortint'($urandom) : shortint'($urandom_range(300));
    if ($urandom_range(99) < 10) s.btn = 15'($urandom);
    else for (int i = 0; i < 15; i++) if ($urandom_range(99) < 10) s.btn[i] = !s.btn[i];
    return s;
  endfunction

  function automatic pad_sample_t mk(bit menu, shortint lx, shortint ly, shortint rx,
                                     shortint ry, bit [14:0] btn, int now);
    pad_sample_t s;
    s.present = 1;
    s.menu = menu;
    s.lx = lx;
    s.ly = ly;
    s.rx = rx;
    s.ry = ry;
    s.tl = 0;
    s.tr = 0;
    s.btn = btn;
    s.now = now;
    return s;
  endfunction

  initial begin
    pad_sample_t s;
    int unsigned phase_regs[4][6] = '{
      '{10, 1, 0, 0, 0, 0},
      '{244, 0, 65535, 65535, 32766, 32767},
      '{255, 1, 40, 20, 12000, 3000},
      '{0, 1, 220, 160, 7849, 8689}
    };
    board = new();
    calm = 0;
    hold_left = 0;
    items = 0;
    menu_items = 0;
    clock_ms = 1000;
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_TRIGGER_LEVEL;
    cfg_data = 0;
    in_valid = 0;
    pad_present = 0;
    menu_mode = 0;
    left_x = 0;
    left_y = 0;
    right_x = 0;
    right_y = 0;
    trigger_left = 0;
    trigger_right = 0;
    button_bits = 0;
    now_time = 0;
    prev_s = mk(0, 0, 0, 0, 0, 0, 0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: sticks at full throw, held repeat, release, edges, absent pad
    send_sample(mk(1, 16'sh7FFF, 0, 0, 16'sh8000, 15'h0800, 1000));
    send_sample(mk(1, 16'sh7FFF, 0, 0, 16'sh8000, 15'h0800, 1100));
    send_sample(mk(1, 16'sh7FFF, 0, 0, 16'sh8000, 15'h0800, 1221));
    send_sample(mk(1, 16'sh7FFF, 0, 0, 16'sh8000, 15'h0800, 1382));
    send_sample(mk(1, 16'sh7FFF, 0, 0, 16'sh8000, 15'h0800, 500));
    send_sample(mk(1, 16'sh8000, 16'sh8000, 16'sh8000, 0, 15'h7000, 600));
    send_sample(mk(1, 0, 16'sh7FFF, 23170, 23170, 15'h0000, 700));
    send_sample(mk(1, 7000, 3000, 0, 0, 15'h0000, 32'sh7FFF_FFFF));
    send_sample(mk(1, 0, 0, 16'sh7FFF, 0, 15'h0800, 32'sh8000_0000));
    send_sample(mk(0, 0, 0, 16'sh7FFF, 0, 15'h7FFF, 0));
    send_sample(mk(0, 0, 0, 0, 0, 15'h0000, 10));
    send_sample(mk(1, 0, 0, 0, 0, 15'h0000, 20));
    s = mk(0, 0, 0, 0, 0, 15'h7FFF, 30);
    s.tl = 16'sh7FFF;
    s.tr = 30;
    send_sample(s);
    s.present = 0;
    send_sample(s);
    s = mk(0, 0, 0, 0, 0, 15'h0180, 40);
    s.tl = 16'sh8000;
    s.tr = 29;
    send_sample(s);
    drain();

    // Random phases at several register settings
    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 6; r++) write_reg(cfg_reg_t'(r), phase_regs[ph][r]);
      for (int i = 0; i < 70; i++) begin
        calm = (ph == 1 && i >= 20 && i < 60);
        if (ph == 0 && i == 30) hold_left = 400;
        if (ph == 2 && i == 35) while (board.pending_q.size() != 0) @(posedge clk);
        send_sample(rand_sample());
      end
      calm = 0;
      drain();
    end
    @(negedge clk);
    in_valid = 0;

    // Final wait for stragglers
    for (int c = 0; c < 5000 && board.pending_q.size() != 0; c++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d samples (%0d in menu mode), %0d key events over 5 register settings",
             items, menu_items, board.seen);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("[gamepad_event_qualifier] OK");
    end else begin
      $display("%0d mismatches, %0d events missing", board.errors, board.pending_q.size());
      $display("[gamepad_event_qualifier] ERROR");
    end
    $finish;
  end

endmodule
